// File: src/tpq_pkg.sv
// Shared constants, command and status codes and cell control types
// for the task priority queue. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tpq_pkg;

    // Parameter defaults
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int NUM_BANKS_DEF   = 4;
    localparam int TIME_BITS_DEF   = 16;

    // Fixed field widths of the transactions
    localparam int CMD_W     = 2;
    localparam int BANK_IN_W = 2;
    localparam int ID_W      = 8;
    localparam int TIME_W    = 16;
    localparam int STATUS_W  = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd3;

    // Write enables broadcast to every cell
    typedef struct packed {
        logic ins;   // insert, bank not full
        logic rem;   // remove, id present
    } t_cell_ctl;

    // Flags handed from one cell to the next
    typedef struct packed {
        logic gt;    // new key goes at or before this slot
        logic seen;  // matching id found at or before this slot
    } t_cell_flag;

endpackage : tpq_pkg

`default_nettype wire

// File: src/tpq_if.sv
// Valid/ready channel interfaces for the task priority queue:
// request (task command) and response (status and head entry). Uses tpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tpq_in_if;
    logic                           valid;
    logic                           ready;
    logic [tpq_pkg::CMD_W-1:0]      cmd;
    logic [tpq_pkg::BANK_IN_W-1:0]  bank;
    logic [tpq_pkg::ID_W-1:0]       task_id;
    logic [tpq_pkg::TIME_W-1:0]     arrival;
    logic [tpq_pkg::TIME_W-1:0]     period;
    logic [tpq_pkg::TIME_W-1:0]     exec_time;
    logic [tpq_pkg::TIME_W-1:0]     deadline;

    modport source (output valid, cmd, bank, task_id, arrival, period, exec_time, deadline,
                    input ready);
    modport sink   (input valid, cmd, bank, task_id, arrival, period, exec_time, deadline,
                    output ready);
endinterface : tpq_in_if

interface tpq_out_if #(
    parameter int CNT_W = 5
);
    logic                           valid;
    logic                           ready;
    logic [tpq_pkg::STATUS_W-1:0]   status;
    logic [CNT_W-1:0]               count;
    logic                           head_valid;
    logic [tpq_pkg::ID_W-1:0]       head_id;
    logic [tpq_pkg::TIME_W-1:0]     head_arrival;
    logic [tpq_pkg::TIME_W-1:0]     head_period;
    logic [tpq_pkg::TIME_W-1:0]     head_exec_time;
    logic [tpq_pkg::TIME_W-1:0]     head_deadline;

    modport source (output valid, status, count, head_valid, head_id, head_arrival,
                    head_period, head_exec_time, head_deadline,
                    input ready);
    modport sink   (input valid, status, count, head_valid, head_id, head_arrival,
                    head_period, head_exec_time, head_deadline,
                    output ready);
endinterface : tpq_out_if

`default_nettype wire

// File: src/tpq_cell.sv
// One slot of the queue row: holds that slot for every bank, compares the
// incoming key and id, and shifts with its neighbours. Uses tpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpq_cell #(
    parameter int IDX       = 0,
    parameter int NUM_BANKS = tpq_pkg::NUM_BANKS_DEF,
    parameter int TIME_BITS = tpq_pkg::TIME_BITS_DEF,
    parameter int CNT_W     = 5,
    parameter int BANK_W    = 2
) (
    input  wire                        i_clk,
    input  wire tpq_pkg::t_cell_ctl    i_ctl,
    input  wire  [BANK_W-1:0]          i_bank,
    input  wire  [CNT_W-1:0]           i_cnt,
    input  wire  [4*TIME_BITS-1:0]     i_key,
    input  wire  [tpq_pkg::ID_W-1:0]   i_id,
    input  wire tpq_pkg::t_cell_flag   i_prev_flag,
    input  wire  [4*TIME_BITS-1:0]     i_prev_key,
    input  wire  [tpq_pkg::ID_W-1:0]   i_prev_id,
    input  wire  [4*TIME_BITS-1:0]     i_next_key,
    input  wire  [tpq_pkg::ID_W-1:0]   i_next_id,
    output tpq_pkg::t_cell_flag        o_flag,
    output logic [4*TIME_BITS-1:0]     o_key,
    output logic [tpq_pkg::ID_W-1:0]   o_id,
    output logic [4*TIME_BITS-1:0]     o_nxt_key,
    output logic [tpq_pkg::ID_W-1:0]   o_nxt_id
);

    localparam int KEY_W = 4 * TIME_BITS;
    localparam int T     = TIME_BITS;

    // Slot storage, one entry per bank
    logic [KEY_W-1:0]          r_key [NUM_BANKS];
    logic [tpq_pkg::ID_W-1:0]  r_id  [NUM_BANKS];

    logic slot_valid;
    logic ahead;
    logic match;
    logic gt;
    logic seen;

    assign o_key = r_key[i_bank];
    assign o_id  = r_id[i_bank];

    assign slot_valid = CNT_W'(IDX) < i_cnt;

    // New key strictly ahead of stored key: arrival, period asc; exec desc; deadline asc
    always_comb begin
        if (i_key[4*T-1:3*T] != o_key[4*T-1:3*T]) begin
            ahead = i_key[4*T-1:3*T] < o_key[4*T-1:3*T];
        end else if (i_key[3*T-1:2*T] != o_key[3*T-1:2*T]) begin
            ahead = i_key[3*T-1:2*T] < o_key[3*T-1:2*T];
        end else if (i_key[2*T-1:T] != o_key[2*T-1:T]) begin
            ahead = i_key[2*T-1:T] > o_key[2*T-1:T];
        end else begin
            ahead = i_key[T-1:0] < o_key[T-1:0];
        end
    end

    // Empty slots count as after the new key, so gt is monotonic along the row
    assign gt    = slot_valid ? ahead : 1'b1;
    assign match = slot_valid && (o_id == i_id);
    assign seen  = i_prev_flag.seen || match;

    assign o_flag.gt   = gt;
    assign o_flag.seen = seen;

    // Next slot value: insert shifts down, remove shifts up
    always_comb begin
        o_nxt_key = o_key;
        o_nxt_id  = o_id;
        if (i_ctl.ins && gt) begin
            if (i_prev_flag.gt) begin
                o_nxt_key = i_prev_key;
                o_nxt_id  = i_prev_id;
            end else begin
                o_nxt_key = i_key;
                o_nxt_id  = i_id;
            end
        end else if (i_ctl.rem && seen) begin
            o_nxt_key = i_next_key;
            o_nxt_id  = i_next_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins || i_ctl.rem) begin
            r_key[i_bank] <= o_nxt_key;
            r_id[i_bank]  <= o_nxt_id;
        end
    end

endmodule : tpq_cell

`default_nettype wire

// File: src/task_priority_queue.sv
// Task priority queue top level: per-bank counts, the row of tpq_cell slots,
// status decode and response register. Uses tpq_pkg, tpq_if and tpq_cell.
// The response is registered and valid in the cycle after a request is taken.
// One transaction per cycle while the response is not stalled; the cell row
// compares and shifts all slots of the addressed bank in the accepting cycle.
// Reset (synchronous, active low) empties every bank and drops response valid;
// slot contents are not cleared and are never read beyond a bank's count.
`timescale 1ns / 1ps
`default_nettype none

module task_priority_queue #(
    parameter int QUEUE_DEPTH = tpq_pkg::QUEUE_DEPTH_DEF,
    parameter int NUM_BANKS   = tpq_pkg::NUM_BANKS_DEF,
    parameter int TIME_BITS   = tpq_pkg::TIME_BITS_DEF,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    tpq_in_if.sink     i_task,
    tpq_out_if.source  o_res
);

    localparam int KEY_W  = 4 * TIME_BITS;
    localparam int BANK_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam int ID_W   = tpq_pkg::ID_W;

    // Per-bank entry counts
    logic [CNT_W-1:0] r_cnt [NUM_BANKS];

    // Response register
    logic                           r_vld;
    logic [tpq_pkg::STATUS_W-1:0]   r_status;
    logic [CNT_W-1:0]               r_count;
    logic                           r_head_vld;
    logic [ID_W-1:0]                r_head_id;
    logic [KEY_W-1:0]               r_head_key;

    logic                           accept;
    logic [tpq_pkg::BANK_IN_W-1:0]  bank_wrap;
    logic [BANK_W-1:0]              bank_sel;
    logic [CNT_W-1:0]               cnt;
    logic [CNT_W-1:0]               n_cnt;
    logic [tpq_pkg::STATUS_W-1:0]   n_status;
    logic                           full;
    logic                           empty;
    logic                           found;
    logic [KEY_W-1:0]               new_key;
    tpq_pkg::t_cell_ctl             ctl;

    // Row links
    tpq_pkg::t_cell_flag  flag_w    [QUEUE_DEPTH];
    logic [KEY_W-1:0]     key_w     [QUEUE_DEPTH];
    logic [ID_W-1:0]      id_w      [QUEUE_DEPTH];
    logic [KEY_W-1:0]     nxt_key_w [QUEUE_DEPTH];
    logic [ID_W-1:0]      nxt_id_w  [QUEUE_DEPTH];

    assign i_task.ready = !r_vld || o_res.ready;
    assign accept       = i_task.valid && i_task.ready;

    // Bank number wraps modulo the bank count (input is at most 3)
    always_comb begin
        if (NUM_BANKS == 1) begin
            bank_wrap = '0;
        end else if (int'(i_task.bank) >= NUM_BANKS) begin
            bank_wrap = i_task.bank - tpq_pkg::BANK_IN_W'(NUM_BANKS);
        end else begin
            bank_wrap = i_task.bank;
        end
    end
    assign bank_sel = BANK_W'(bank_wrap);

    assign new_key = {i_task.arrival[TIME_BITS-1:0], i_task.period[TIME_BITS-1:0],
                      i_task.exec_time[TIME_BITS-1:0], i_task.deadline[TIME_BITS-1:0]};

    assign cnt   = r_cnt[bank_sel];
    assign full  = cnt >= CNT_W'(QUEUE_DEPTH);
    assign empty = cnt == '0;
    assign found = flag_w[QUEUE_DEPTH-1].seen;

    // Command decode: status, new count and cell write enables
    always_comb begin
        n_status = tpq_pkg::STATUS_OK;
        n_cnt    = cnt;
        ctl      = '0;
        case (i_task.cmd)
            tpq_pkg::CMD_INSERT: begin
                if (full) begin
                    n_status = tpq_pkg::STATUS_FULL;
                end else begin
                    ctl.ins = accept;
                    n_cnt   = cnt + 1'b1;
                end
            end
            tpq_pkg::CMD_REMOVE: begin
                if (empty) begin
                    n_status = tpq_pkg::STATUS_EMPTY;
                end else if (!found) begin
                    n_status = tpq_pkg::STATUS_NOT_FOUND;
                end else begin
                    ctl.rem = accept;
                    n_cnt   = cnt - 1'b1;
                end
            end
            tpq_pkg::CMD_CLEAR: begin
                n_cnt = '0;
            end
            default: begin
                n_cnt = cnt;
            end
        endcase
    end

    // Row of slot cells
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        tpq_pkg::t_cell_flag  prev_flag;
        logic [KEY_W-1:0]     prev_key;
        logic [ID_W-1:0]      prev_id;
        logic [KEY_W-1:0]     next_key;
        logic [ID_W-1:0]      next_id;

        if (g == 0) begin : g_first
            assign prev_flag = '0;
            assign prev_key  = new_key;
            assign prev_id   = i_task.task_id;
        end else begin : g_mid
            assign prev_flag = flag_w[g-1];
            assign prev_key  = key_w[g-1];
            assign prev_id   = id_w[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign next_key = key_w[g];
            assign next_id  = id_w[g];
        end else begin : g_inner
            assign next_key = key_w[g+1];
            assign next_id  = id_w[g+1];
        end

        tpq_cell #(
            .IDX       (g),
            .NUM_BANKS (NUM_BANKS),
            .TIME_BITS (TIME_BITS),
            .CNT_W     (CNT_W),
            .BANK_W    (BANK_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_bank      (bank_sel),
            .i_cnt       (cnt),
            .i_key       (new_key),
            .i_id        (i_task.task_id),
            .i_prev_flag (prev_flag),
            .i_prev_key  (prev_key),
            .i_prev_id   (prev_id),
            .i_next_key  (next_key),
            .i_next_id   (next_id),
            .o_flag      (flag_w[g]),
            .o_key       (key_w[g]),
            .o_id        (id_w[g]),
            .o_nxt_key   (nxt_key_w[g]),
            .o_nxt_id    (nxt_id_w[g])
        );
    end

    // Counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BANKS; b++) begin
                r_cnt[b] <= '0;
            end
        end else if (accept) begin
            r_cnt[bank_sel] <= n_cnt;
        end
    end

    // Response valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_vld <= 1'b0;
        end
    end

    // Response payload: head taken from the first cell's next value
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status   <= n_status;
            r_count    <= n_cnt;
            r_head_vld <= n_cnt != '0;
            r_head_id  <= (n_cnt != '0) ? nxt_id_w[0] : '0;
            r_head_key <= (n_cnt != '0) ? nxt_key_w[0] : '0;
        end
    end

    assign o_res.valid          = r_vld;
    assign o_res.status         = r_status;
    assign o_res.count          = r_count;
    assign o_res.head_valid     = r_head_vld;
    assign o_res.head_id        = r_head_id;
    assign o_res.head_arrival   = tpq_pkg::TIME_W'(r_head_key[4*TIME_BITS-1:3*TIME_BITS]);
    assign o_res.head_period    = tpq_pkg::TIME_W'(r_head_key[3*TIME_BITS-1:2*TIME_BITS]);
    assign o_res.head_exec_time = tpq_pkg::TIME_W'(r_head_key[2*TIME_BITS-1:TIME_BITS]);
    assign o_res.head_deadline  = tpq_pkg::TIME_W'(r_head_key[TIME_BITS-1:0]);

endmodule : task_priority_queue

`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for task_priority_queue: drives task commands, predicts
// status, count and head entry per bank, and compares every response transaction.
// Depends on tpq_pkg, tpq_if and the task_priority_queue RTL.
`timescale 1ns / 1ps

module testbench;

    import tpq_pkg::*;

    localparam int DEPTH       = QUEUE_DEPTH_DEF;
    localparam int BANKS       = NUM_BANKS_DEF;
    localparam int CNT_BITS    = $clog2(DEPTH + 1);
    localparam int HOLD_CYCLES = 64;
    localparam int STALL_LIMIT = 2000;
    localparam int PRINT_LIMIT = 40;
    localparam int RANDOM_ITEMS = 500;

    // Command code the block does not define
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] exec_time;
        logic [TIME_W-1:0] deadline;
    } t_task_key;

    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [BANK_IN_W-1:0] bank;
        logic [ID_W-1:0]      task_id;
        t_task_key            key;
    } t_task_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CNT_BITS-1:0] count;
        logic                head_valid;
        logic [ID_W-1:0]     head_id;
        t_task_key           head_key;
    } t_head_report;

    logic i_clk;
    logic i_rst_n;

    tpq_in_if                      task_if ();
    tpq_out_if #(.CNT_W(CNT_BITS)) res_if ();

    task_priority_queue #(
        .QUEUE_DEPTH (DEPTH),
        .NUM_BANKS   (BANKS),
        .TIME_BITS   (TIME_BITS_DEF),
        .CNT_W       (CNT_BITS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_task  (task_if.sink),
        .o_res   (res_if.source)
    );

    wire task_fire = task_if.valid && task_if.ready;
    wire res_fire  = res_if.valid && res_if.ready;

    // Mirror of the queue contents, one ordered list per bank
    t_task_key slot_key [BANKS][DEPTH];
    logic [ID_W-1:0] slot_id [BANKS][DEPTH];
    int bank_fill [BANKS];

    t_head_report pending_reports [$];

    int error_count;
    int results_checked;
    int insert_tally, full_tally, remove_tally, not_found_tally, empty_tally;
    int clear_tally, request_tally;
    bit steady;
    bit hold_request;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // True when key a must stand strictly ahead of key b
    function automatic bit key_precedes(input t_task_key a, input t_task_key b);
        if (a.arrival != b.arrival) return a.arrival < b.arrival;
        if (a.period != b.period) return a.period < b.period;
        if (a.exec_time != b.exec_time) return a.exec_time > b.exec_time;
        return a.deadline < b.deadline;
    endfunction

    // Applies one command to the mirror and returns the response it should give
    function automatic t_head_report predict_head_report(input t_task_req r);
        int b, n, pos, i;
        t_head_report rep;
        b = int'(r.bank) % BANKS;
        n = bank_fill[b];
        rep = '0;
        rep.status = STATUS_OK;
        case (r.cmd)
            CMD_INSERT: begin
                insert_tally++;
                if (n >= DEPTH) begin
                    rep.status = STATUS_FULL;
                    full_tally++;
                end else begin
                    pos = n;
                    for (i = 0; i < n; i++) begin
                        if (key_precedes(r.key, slot_key[b][i])) begin
                            pos = i;
                            break;
                        end
                    end
                    for (i = n; i > pos; i--) begin
                        slot_key[b][i] = slot_key[b][i-1];
                        slot_id[b][i]  = slot_id[b][i-1];
                    end
                    slot_key[b][pos] = r.key;
                    slot_id[b][pos]  = r.task_id;
                    n++;
                end
            end
            CMD_REMOVE: begin
                remove_tally++;
                if (n == 0) begin
                    rep.status = STATUS_EMPTY;
                    empty_tally++;
                end else begin
                    pos = n;
                    for (i = 0; i < n; i++) begin
                        if (slot_id[b][i] == r.task_id) begin
                            pos = i;
                            break;
                        end
                    end
                    if (pos == n) begin
                        rep.status = STATUS_NOT_FOUND;
                        not_found_tally++;
                    end else begin
                        for (i = pos; i + 1 < n; i++) begin
                            slot_key[b][i] = slot_key[b][i+1];
                            slot_id[b][i]  = slot_id[b][i+1];
                        end
                        n--;
                    end
                end
            end
            CMD_CLEAR: begin
                clear_tally++;
                n = 0;
            end
            default: ;
        endcase
        bank_fill[b] = n;
        rep.count = CNT_BITS'(n);
        rep.head_valid = (n > 0);
        if (n > 0) begin
            rep.head_id  = slot_id[b][0];
            rep.head_key = slot_key[b][0];
        end
        return rep;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0h, want %0h",
                                      results_checked, name, got, want));
    endtask

    // Predict on every accepted request transaction
    always @(posedge i_clk) begin : request_monitor
        t_task_req req;
        if (i_rst_n && task_fire) begin
            req.cmd       = task_if.cmd;
            req.bank      = task_if.bank;
            req.task_id   = task_if.task_id;
            req.key.arrival   = task_if.arrival;
            req.key.period    = task_if.period;
            req.key.exec_time = task_if.exec_time;
            req.key.deadline  = task_if.deadline;
            request_tally++;
            pending_reports.push_back(predict_head_report(req));
        end
    end

    // Compare each response transaction with the oldest prediction
    always @(posedge i_clk) begin : response_checker
        t_head_report want;
        if (i_rst_n && res_fire) begin
            if (pending_reports.size() == 0) begin
                report_mismatch("response with no request outstanding");
            end else begin
                want = pending_reports.pop_front();
                check_field("status",         res_if.status,         want.status);
                check_field("count",          res_if.count,          want.count);
                check_field("head_valid",     res_if.head_valid,     want.head_valid);
                check_field("head_id",        res_if.head_id,        want.head_id);
                check_field("head_arrival",   res_if.head_arrival,   want.head_key.arrival);
                check_field("head_period",    res_if.head_period,    want.head_key.period);
                check_field("head_exec_time", res_if.head_exec_time, want.head_key.exec_time);
                check_field("head_deadline",  res_if.head_deadline,  want.head_key.deadline);
                results_checked++;
            end
        end
    end

    // Response side: random stalls, plus one long hold-off on request
    initial begin : response_sink
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                res_if.ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                res_if.ready <= steady || ($urandom_range(0, 99) >= 19);
            end
        end
    end

    // Ends the run if no transaction moves on either side for too long
    always @(posedge i_clk) begin : watchdog
        int quiet_cycles;
        if (!i_rst_n || task_fire || res_fire) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("testbench failed");
                $finish;
            end
        end
    end

    function automatic t_task_req task_req(input logic [CMD_W-1:0] cmd,
                                           input logic [BANK_IN_W-1:0] bank,
                                           input logic [ID_W-1:0] id,
                                           input logic [TIME_W-1:0] arrival,
                                           input logic [TIME_W-1:0] period,
                                           input logic [TIME_W-1:0] exec_time,
                                           input logic [TIME_W-1:0] deadline);
        t_task_req r;
        r.cmd = cmd;
        r.bank = bank;
        r.task_id = id;
        r.key.arrival = arrival;
        r.key.period = period;
        r.key.exec_time = exec_time;
        r.key.deadline = deadline;
        return r;
    endfunction

    // Mostly tiny values so that keys tie often, with extremes and full range
    function automatic logic [TIME_W-1:0] random_tick();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5) return TIME_W'($urandom_range(0, 3));
        if (sel == 5) return '0;
        if (sel == 6) return '1;
        return TIME_W'($urandom_range(0, 65535));
    endfunction

    // Insert-heavy mix so banks fill up; removals mostly name a queued id
    function automatic t_task_req random_task_req();
        int sel, b, n;
        t_task_req r;
        sel = $urandom_range(0, 99);
        b = $urandom_range(0, BANKS - 1);
        n = bank_fill[b];
        r.bank = BANK_IN_W'(b);
        r.key.arrival = random_tick();
        r.key.period = random_tick();
        r.key.exec_time = random_tick();
        r.key.deadline = random_tick();
        if ($urandom_range(0, 1) != 0)
            r.task_id = ID_W'($urandom_range(0, 7));
        else
            r.task_id = ID_W'($urandom_range(0, 255));
        if (sel < 64) begin
            r.cmd = CMD_INSERT;
        end else if (sel < 95) begin
            r.cmd = CMD_REMOVE;
            if (n > 0 && $urandom_range(0, 99) < 80)
                r.task_id = slot_id[b][$urandom_range(0, n - 1)];
        end else if (sel < 97) begin
            r.cmd = CMD_CLEAR;
        end else begin
            r.cmd = CMD_UNUSED;
        end
        return r;
    endfunction

    // Offers one request transaction; returns at the edge where it is taken
    task automatic send_task(input t_task_req r);
        while (!steady && $urandom_range(0, 99) < 19) begin
            task_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        task_if.valid     <= 1'b1;
        task_if.cmd       <= r.cmd;
        task_if.bank      <= r.bank;
        task_if.task_id   <= r.task_id;
        task_if.arrival   <= r.key.arrival;
        task_if.period    <= r.key.period;
        task_if.exec_time <= r.key.exec_time;
        task_if.deadline  <= r.key.deadline;
        do @(posedge i_clk); while (!task_if.ready);
    endtask

    // Removal and clear on banks that have never held anything
    task automatic test_empty_banks();
        send_task(task_req(CMD_REMOVE, 2'd0, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_task(task_req(CMD_CLEAR,  2'd3, 8'h5A, 16'h1234, 16'h0000, 16'hFFFF, 16'h0001));
        send_task(task_req(CMD_REMOVE, 2'd2, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    endtask

    // Each level of the sort key, a stable tie and both ends of the time range
    task automatic test_key_order();
        send_task(task_req(CMD_INSERT, 2'd0, 8'hFF, 16'h0010, 16'h0005, 16'h0003, 16'h0007));
        send_task(task_req(CMD_INSERT, 2'd0, 8'h01, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_task(task_req(CMD_INSERT, 2'd0, 8'h02, 16'h0010, 16'h0004, 16'h0003, 16'h0007));
        send_task(task_req(CMD_INSERT, 2'd0, 8'h03, 16'h0010, 16'h0005, 16'h0004, 16'h0007));
        send_task(task_req(CMD_INSERT, 2'd0, 8'h04, 16'h0010, 16'h0005, 16'h0003, 16'h0006));
        send_task(task_req(CMD_INSERT, 2'd0, 8'h05, 16'h0010, 16'h0005, 16'h0003, 16'h0007));
        send_task(task_req(CMD_INSERT, 2'd0, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        // duplicate id that lands at the head
        send_task(task_req(CMD_INSERT, 2'd0, 8'hFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    endtask

    // Absent id, duplicate id taken from the head, then two removals at the tail
    task automatic test_remove_cases();
        send_task(task_req(CMD_REMOVE, 2'd0, 8'h77, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_task(task_req(CMD_REMOVE, 2'd0, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_task(task_req(CMD_REMOVE, 2'd0, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_task(task_req(CMD_REMOVE, 2'd0, 8'h05, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    endtask

    // Undefined command code leaves the bank as it is
    task automatic test_unused_command();
        send_task(task_req(CMD_UNUSED, 2'd0, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    endtask

    task automatic test_clear_bank();
        send_task(task_req(CMD_CLEAR, 2'd0, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    endtask

    // Fill one bank to the brim, overflow it, then free a slot and refill
    task automatic test_bank_full();
        t_task_req r;
        repeat (DEPTH + 1) begin
            r = random_task_req();
            r.cmd = CMD_INSERT;
            r.bank = 2'd1;
            send_task(r);
        end
        send_task(task_req(CMD_REMOVE, 2'd1, slot_id[1][DEPTH/2],
                           16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_task(task_req(CMD_INSERT, 2'd1, 8'hA5, 16'h8000, 16'h0001, 16'h8000, 16'h0001));
        send_task(task_req(CMD_INSERT, 2'd1, 8'h5A, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    endtask

    // Response side holds off while requests keep coming
    task automatic test_backpressure();
        hold_request = 1'b1;
        repeat (16) send_task(random_task_req());
    endtask

    task automatic test_random_mix(input int items);
        int k;
        for (k = 0; k < items; k++) begin
            steady = (k >= items / 3) && (k < items / 3 + 100);
            send_task(random_task_req());
        end
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        task_if.valid = 1'b0;
        task_if.cmd = '0;
        task_if.bank = '0;
        task_if.task_id = '0;
        task_if.arrival = '0;
        task_if.period = '0;
        task_if.exec_time = '0;
        task_if.deadline = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_banks();
        test_key_order();
        test_remove_cases();
        test_unused_command();
        test_clear_bank();
        test_bank_full();
        test_backpressure();
        test_random_mix(RANDOM_ITEMS);
        task_if.valid <= 1'b0;

        // let the last request reach the scoreboard, then drain the responses
        @(posedge i_clk);
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Ran %0d requests: %0d inserts (%0d refused full), %0d removals",
                 request_tally, insert_tally, full_tally, remove_tally);
        $display("(%0d id absent, %0d empty bank), %0d clears; %0d responses checked",
                 not_found_tally, empty_tally, clear_tally, results_checked);
        if (error_count == 0 && pending_reports.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule : testbench
